// ===== hdl/rbsi_pkg.sv =====
// rbsi_pkg: shared constants and types for the ray/box slab intersection block
// register indexes, face codes and the per-lane flag bundle
// no dependencies
package rbsi_pkg;

	localparam int CFG_INDEX_WIDTH = 3;
	localparam int TOL_WIDTH       = 16;
	localparam int FACE_WIDTH      = 3;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MIN_X = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MIN_Y = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MIN_Z = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MAX_X = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MAX_Y = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MAX_Z = 3'd5;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FACE_TOL  = 3'd6;

	localparam logic [FACE_WIDTH-1:0] FACE_NEG_X = 3'd0;
	localparam logic [FACE_WIDTH-1:0] FACE_POS_X = 3'd1;
	localparam logic [FACE_WIDTH-1:0] FACE_NEG_Y = 3'd2;
	localparam logic [FACE_WIDTH-1:0] FACE_POS_Y = 3'd3;
	localparam logic [FACE_WIDTH-1:0] FACE_NEG_Z = 3'd4;
	localparam logic [FACE_WIDTH-1:0] FACE_POS_Z = 3'd5;

	localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd66;

	typedef struct packed {
		logic par;    // direction component is zero
		logic pmiss;  // zero direction and origin outside the slab
	} lane_flag_t;

endpackage

// ===== hdl/rbsi_div.sv =====
// rbsi_div: pipelined restoring divider, one quotient bit per stage
// computes n * 2^F / d truncated, saturated to a signed W-bit result
// depends on nothing
module rbsi_div #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                en,
	input  logic [W:0]          n_mag,
	input  logic [W-1:0]        d_mag,
	input  logic                neg,
	output logic signed [W-1:0] q
);
	localparam int NW = W + 1 + F;
	localparam logic [NW-1:0] HALF = NW'(1) << (W - 1);

	logic [W-1:0]  rem_q [NW];
	logic [NW-1:0] dq_q  [NW];
	logic [W-1:0]  ad_q  [NW];
	logic          neg_q [NW];

	logic [W-1:0]  rem_in [NW];
	logic [NW-1:0] dq_in  [NW];
	logic [W-1:0]  ad_in  [NW];
	logic          neg_in [NW];

	logic signed [W-1:0] q_q;

	genvar k;
	generate
		for (k = 0; k < NW; k++) begin : g_stage
			logic [W:0] trial;
			logic [W:0] diff;
			logic       ge;
			if (k == 0) begin : g_first
				assign rem_in[k] = '0;
				assign dq_in[k]  = {n_mag, F'(0)};
				assign ad_in[k]  = d_mag;
				assign neg_in[k] = neg;
			end else begin : g_next
				assign rem_in[k] = rem_q[k-1];
				assign dq_in[k]  = dq_q[k-1];
				assign ad_in[k]  = ad_q[k-1];
				assign neg_in[k] = neg_q[k-1];
			end
			assign trial = {rem_in[k], dq_in[k][NW-1]};
			assign ge    = trial >= {1'b0, ad_in[k]};
			assign diff  = trial - {1'b0, ad_in[k]};
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[k] <= ge ? diff[W-1:0] : trial[W-1:0];
					dq_q[k]  <= {dq_in[k][NW-2:0], ge};
					ad_q[k]  <= ad_in[k];
					neg_q[k] <= neg_in[k];
				end
			end
		end
	endgenerate

	logic [NW-1:0] qv;
	logic [W-1:0]  qsat;
	assign qv = dq_q[NW-1];

	always_comb begin
		if (neg_q[NW-1]) begin
			if (qv > HALF) qsat = {1'b1, (W-1)'(0)};
			else qsat = W'(0) - qv[W-1:0];
		end else begin
			if (qv >= HALF) qsat = {1'b0, {(W-1){1'b1}}};
			else qsat = qv[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_q <= $signed(qsat);
		end
	end

	assign q = q_q;
endmodule

// ===== hdl/rbsi_lane.sv =====
// rbsi_lane: one axis of the slab test, entry and exit distances ordered
// uses rbsi_div twice and rbsi_pkg::lane_flag_t
// advances on en
module rbsi_lane #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] o,
	input  logic signed [W-1:0] d,
	input  logic signed [W-1:0] bmin,
	input  logic signed [W-1:0] bmax,
	output logic signed [W-1:0] ta,
	output logic signed [W-1:0] tb,
	output logic signed [W-1:0] o_out,
	output logic signed [W-1:0] d_out,
	output rbsi_pkg::lane_flag_t flags
);
	localparam int DL = W + F + 2;

	logic signed [W:0]   nmin_s1, nmax_s1;
	logic signed [W-1:0] o_s1, d_s1;
	rbsi_pkg::lane_flag_t fl_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			nmin_s1   <= $signed({bmin[W-1], bmin}) - $signed({o[W-1], o});
			nmax_s1   <= $signed({bmax[W-1], bmax}) - $signed({o[W-1], o});
			o_s1      <= o;
			d_s1      <= d;
			fl_s1.par <= (d == '0);
			fl_s1.pmiss <= (d == '0) && ((o < bmin) || (o > bmax));
		end
	end

	logic [W:0]   amin, amax;
	logic [W-1:0] ad;
	logic         dneg, negmin, negmax;
	assign amin   = nmin_s1[W] ? (W+1)'(0) - nmin_s1 : nmin_s1;
	assign amax   = nmax_s1[W] ? (W+1)'(0) - nmax_s1 : nmax_s1;
	assign dneg   = d_s1[W-1];
	assign ad     = dneg ? W'(0) - d_s1 : d_s1;
	assign negmin = nmin_s1[W] ^ dneg;
	assign negmax = nmax_s1[W] ^ dneg;

	logic signed [W-1:0] qa, qb;

	rbsi_div #(.W(W), .F(F)) u_div_min (
		.clk(clk), .en(en),
		.n_mag(amin), .d_mag(ad), .neg(negmin), .q(qa)
	);

	rbsi_div #(.W(W), .F(F)) u_div_max (
		.clk(clk), .en(en),
		.n_mag(amax), .d_mag(ad), .neg(negmax), .q(qb)
	);

	// side data follows the divider
	logic signed [W-1:0]  o_dl_q  [DL];
	logic signed [W-1:0]  d_dl_q  [DL];
	rbsi_pkg::lane_flag_t fl_dl_q [DL];

	always_ff @(posedge clk) begin
		if (en) begin
			o_dl_q[0]  <= o_s1;
			d_dl_q[0]  <= d_s1;
			fl_dl_q[0] <= fl_s1;
			for (int i = 1; i < DL; i++) begin
				o_dl_q[i]  <= o_dl_q[i-1];
				d_dl_q[i]  <= d_dl_q[i-1];
				fl_dl_q[i] <= fl_dl_q[i-1];
			end
		end
	end

	logic signed [W-1:0]  ta_q, tb_q, o_q, d_q;
	rbsi_pkg::lane_flag_t fl_q;

	always_ff @(posedge clk) begin
		if (en) begin
			ta_q <= (qa > qb) ? qb : qa;
			tb_q <= (qa > qb) ? qa : qb;
			o_q  <= o_dl_q[DL-1];
			d_q  <= d_dl_q[DL-1];
			fl_q <= fl_dl_q[DL-1];
		end
	end

	assign ta    = ta_q;
	assign tb    = tb_q;
	assign o_out = o_q;
	assign d_out = d_q;
	assign flags = fl_q;
endmodule

// ===== hdl/rbsi_merge.sv =====
// rbsi_merge: combines the three lane intervals into entry distance and miss
// depends on rbsi_pkg::lane_flag_t
// one registered stage
module rbsi_merge #(
	parameter int W = 32
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [W-1:0]  ta [3],
	input  logic signed [W-1:0]  tb [3],
	input  rbsi_pkg::lane_flag_t fl [3],
	output logic signed [W-1:0]  tmin,
	output logic                 miss
);
	localparam logic signed [W-1:0] SMIN = {1'b1, (W-1)'(0)};
	localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};

	logic signed [W-1:0] lo, hi;
	logic                pm;

	// interval only narrows, so an early empty stays empty
	always_comb begin
		lo = SMIN;
		hi = SMAX;
		pm = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (!fl[i].par) begin
				if (ta[i] > lo) lo = ta[i];
				if (tb[i] < hi) hi = tb[i];
			end
			pm = pm | fl[i].pmiss;
		end
	end

	logic signed [W-1:0] tmin_q;
	logic                miss_q;

	always_ff @(posedge clk) begin
		if (en) begin
			tmin_q <= lo;
			miss_q <= pm || (lo > hi) || hi[W-1];
		end
	end

	assign tmin = tmin_q;
	assign miss = miss_q;
endmodule

// ===== hdl/rbsi_point.sv =====
// rbsi_point: hit point coordinate, origin plus distance times direction
// depends on nothing
// three registered stages: align, multiply, scale and saturate
module rbsi_point #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] o,
	input  logic signed [W-1:0] d,
	input  logic signed [W-1:0] tmin,
	output logic signed [W-1:0] p
);
	localparam int MW = 2 * W - F;
	localparam logic [MW-1:0] BIG = MW'(1) << W;

	logic signed [W-1:0] o_s1, d_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			o_s1 <= o;
			d_s1 <= d;
		end
	end

	logic [W-1:0] at, ad;
	assign at = tmin[W-1] ? W'(0) - tmin : tmin;
	assign ad = d_s1[W-1] ? W'(0) - d_s1 : d_s1;

	logic [2*W-1:0]      prod_s2;
	logic                neg_s2;
	logic signed [W-1:0] o_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= at * ad;
			neg_s2  <= tmin[W-1] ^ d_s1[W-1];
			o_s2    <= o_s1;
		end
	end

	logic [MW-1:0]       mfull;
	logic [W:0]          mc;
	logic signed [W+1:0] term, sum;
	logic [W-1:0]        psat;
	assign mfull = prod_s2[2*W-1:F];
	assign mc    = (mfull > BIG) ? {1'b1, W'(0)} : mfull[W:0];
	assign term  = neg_s2 ? (W+2)'(0) - $signed({1'b0, mc}) : $signed({1'b0, mc});
	assign sum   = $signed({{2{o_s2[W-1]}}, o_s2}) + term;

	always_comb begin
		if (sum > $signed({2'b00, 1'b0, {(W-1){1'b1}}})) psat = {1'b0, {(W-1){1'b1}}};
		else if (sum < $signed({2'b11, 1'b1, (W-1)'(0)})) psat = {1'b1, (W-1)'(0)};
		else psat = sum[W-1:0];
	end

	logic signed [W-1:0] p_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			p_s3 <= $signed(psat);
		end
	end

	assign p = p_s3;
endmodule

// ===== hdl/ray_box_slab_intersect.sv =====
// ray_box_slab_intersect: ray against axis-aligned box, slab method, fixed point
// depends on rbsi_pkg, rbsi_lane, rbsi_div, rbsi_merge, rbsi_point
//
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------
// in       | in_valid / in_ready  | origin_x/y/z, direction_x/y/z
// out      | out_valid / out_ready| hit, hit_distance, hit_x/y/z, face
// cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// one item per cycle while the output is not stalled; the pipeline depth is set by the
// bit-per-stage dividers in the three axis lanes (49 stages at Q16.16)
// reset clears the valid line and loads the box registers with the unit box
// the whole pipeline holds while a result waits and out_ready is low
module ray_box_slab_intersect #(
	parameter int COORD_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [COORD_WIDTH-1:0]   origin_x,
	input  logic signed [COORD_WIDTH-1:0]   origin_y,
	input  logic signed [COORD_WIDTH-1:0]   origin_z,
	input  logic signed [COORD_WIDTH-1:0]   direction_x,
	input  logic signed [COORD_WIDTH-1:0]   direction_y,
	input  logic signed [COORD_WIDTH-1:0]   direction_z,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            hit,
	output logic signed [COORD_WIDTH-1:0]   hit_distance,
	output logic signed [COORD_WIDTH-1:0]   hit_x,
	output logic signed [COORD_WIDTH-1:0]   hit_y,
	output logic signed [COORD_WIDTH-1:0]   hit_z,
	output logic [rbsi_pkg::FACE_WIDTH-1:0] face,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rbsi_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [COORD_WIDTH-1:0]          cfg_data
);
	localparam int W   = COORD_WIDTH;
	localparam int F   = FRACTION_BITS;
	localparam int LAT = W + F + 7;

	logic signed [W-1:0]            bmin_q [3];
	logic signed [W-1:0]            bmax_q [3];
	logic [rbsi_pkg::TOL_WIDTH-1:0] tol_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				bmin_q[i] <= '0;
				bmax_q[i] <= W'(1) << F;
			end
			tol_q <= rbsi_pkg::TOL_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				rbsi_pkg::REG_BOX_MIN_X: bmin_q[0] <= $signed(cfg_data);
				rbsi_pkg::REG_BOX_MIN_Y: bmin_q[1] <= $signed(cfg_data);
				rbsi_pkg::REG_BOX_MIN_Z: bmin_q[2] <= $signed(cfg_data);
				rbsi_pkg::REG_BOX_MAX_X: bmax_q[0] <= $signed(cfg_data);
				rbsi_pkg::REG_BOX_MAX_Y: bmax_q[1] <= $signed(cfg_data);
				rbsi_pkg::REG_BOX_MAX_Z: bmax_q[2] <= $signed(cfg_data);
				rbsi_pkg::REG_FACE_TOL:  tol_q <= cfg_data[rbsi_pkg::TOL_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	logic adv;
	logic out_valid_q;
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	logic [LAT-1:0] v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q         <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_q         <= {v_q[LAT-2:0], in_valid};
			out_valid_q <= v_q[LAT-1];
		end
	end

	logic signed [W-1:0]  o_in [3], d_in [3];
	logic signed [W-1:0]  ta [3], tb [3], o_l [3], d_l [3], p [3];
	rbsi_pkg::lane_flag_t fl [3];

	assign o_in[0] = origin_x;
	assign o_in[1] = origin_y;
	assign o_in[2] = origin_z;
	assign d_in[0] = direction_x;
	assign d_in[1] = direction_y;
	assign d_in[2] = direction_z;

	logic signed [W-1:0] tmin_m;
	logic                miss_m;

	genvar a;
	generate
		for (a = 0; a < 3; a++) begin : g_axis
			rbsi_lane #(.W(W), .F(F)) u_lane (
				.clk(clk), .en(adv),
				.o(o_in[a]), .d(d_in[a]), .bmin(bmin_q[a]), .bmax(bmax_q[a]),
				.ta(ta[a]), .tb(tb[a]), .o_out(o_l[a]), .d_out(d_l[a]), .flags(fl[a])
			);
			rbsi_point #(.W(W), .F(F)) u_point (
				.clk(clk), .en(adv),
				.o(o_l[a]), .d(d_l[a]), .tmin(tmin_m), .p(p[a])
			);
		end
	endgenerate

	rbsi_merge #(.W(W)) u_merge (
		.clk(clk), .en(adv),
		.ta(ta), .tb(tb), .fl(fl), .tmin(tmin_m), .miss(miss_m)
	);

	// line the interval up with the hit point stages
	logic signed [W-1:0] tmin_s2, tmin_s3;
	logic                miss_s2, miss_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			tmin_s2 <= tmin_m;
			miss_s2 <= miss_m;
			tmin_s3 <= tmin_s2;
			miss_s3 <= miss_s2;
		end
	end

	function automatic logic near_face(logic signed [W-1:0] pv, logic signed [W-1:0] cv,
			logic [rbsi_pkg::TOL_WIDTH-1:0] tv);
		logic signed [W:0] df;
		logic [W:0]        dm;
		df = $signed({pv[W-1], pv}) - $signed({cv[W-1], cv});
		dm = df[W] ? (W+1)'(0) - df : df;
		return dm < (W+1)'(tv);
	endfunction

	logic [rbsi_pkg::FACE_WIDTH-1:0] face_c;
	always_comb begin
		if (near_face(p[0], bmin_q[0], tol_q)) face_c = rbsi_pkg::FACE_NEG_X;
		else if (near_face(p[0], bmax_q[0], tol_q)) face_c = rbsi_pkg::FACE_POS_X;
		else if (near_face(p[1], bmin_q[1], tol_q)) face_c = rbsi_pkg::FACE_NEG_Y;
		else if (near_face(p[1], bmax_q[1], tol_q)) face_c = rbsi_pkg::FACE_POS_Y;
		else if (near_face(p[2], bmin_q[2], tol_q)) face_c = rbsi_pkg::FACE_NEG_Z;
		else face_c = rbsi_pkg::FACE_POS_Z;
	end

	logic                            hit_q;
	logic signed [W-1:0]             dist_q, hx_q, hy_q, hz_q;
	logic [rbsi_pkg::FACE_WIDTH-1:0] face_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q  <= !miss_s3;
			dist_q <= miss_s3 ? '0 : tmin_s3;
			hx_q   <= miss_s3 ? '0 : p[0];
			hy_q   <= miss_s3 ? '0 : p[1];
			hz_q   <= miss_s3 ? '0 : p[2];
			face_q <= miss_s3 ? '0 : face_c;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign hit_distance = dist_q;
	assign hit_x        = hx_q;
	assign hit_y        = hy_q;
	assign hit_z        = hz_q;
	assign face         = face_q;
endmodule

// ===== test/ray_box_slab_intersect_tb.sv =====
// ray_box_slab_intersect_tb: self-checking bench for the ray/box slab intersection block
// drives rays and box settings through the valid/ready ports and predicts each result
// depends on rbsi_pkg and ray_box_slab_intersect
`timescale 1ns / 1ps

module ray_box_slab_intersect_tb;

	localparam int CW = 32;
	localparam int FB = 16;
	localparam longint ONE = 64'sd65536;
	localparam longint SMAX = 64'sd2147483647;
	localparam longint SMIN = -64'sd2147483648;
	localparam int STALL_LIMIT = 5000;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct {
		logic                            hit;
		coord_t                          hit_dist;
		coord_t                          px;
		coord_t                          py;
		coord_t                          pz;
		logic [rbsi_pkg::FACE_WIDTH-1:0] face;
	} ray_result_t;

	function automatic longint clamp_coord(longint v);
		if (v > SMAX) return SMAX;
		if (v < SMIN) return SMIN;
		return v;
	endfunction

	class box_scoreboard;
		longint                bmin[3];
		longint                bmax[3];
		longint                tol;
		ray_result_t           pending_hits[$];
		int                    errors;
		int                    rays;
		int                    hits;
		int                    misses;

		function new();
			for (int i = 0; i < 3; i++) begin
				bmin[i] = 0;
				bmax[i] = ONE;
			end
			tol = rbsi_pkg::TOL_RESET;
		endfunction

		function void write_reg(logic [rbsi_pkg::CFG_INDEX_WIDTH-1:0] idx, logic [CW-1:0] data);
			case (idx)
				rbsi_pkg::REG_BOX_MIN_X, rbsi_pkg::REG_BOX_MIN_Y,
				rbsi_pkg::REG_BOX_MIN_Z: begin
					bmin[idx] = longint'(coord_t'(data));
				end
				rbsi_pkg::REG_BOX_MAX_X, rbsi_pkg::REG_BOX_MAX_Y,
				rbsi_pkg::REG_BOX_MAX_Z: begin
					bmax[idx - rbsi_pkg::REG_BOX_MAX_X] = longint'(coord_t'(data));
				end
				rbsi_pkg::REG_FACE_TOL: begin
					tol = longint'(data[rbsi_pkg::TOL_WIDTH-1:0]);
				end
				default: ;
			endcase
		endfunction

		// (n << FB) / d toward zero, saturated
		function longint slab_dist(longint n, longint d);
			bit neg;
			longint unsigned an, ad, q;
			neg = (n < 0) != (d < 0);
			an = (n < 0) ? -n : n;
			ad = (d < 0) ? -d : d;
			q = (an << FB) / ad;
			if (neg) begin
				if (q > 64'd2147483648) q = 64'd2147483648;
				return -longint'(q);
			end
			if (q > 64'd2147483647) q = 64'd2147483647;
			return longint'(q);
		endfunction

		function longint scaled_mul(longint a, longint b);
			bit neg;
			longint unsigned m;
			neg = (a < 0) != (b < 0);
			m = (longint'((a < 0) ? -a : a) * longint'((b < 0) ? -b : b)) >> FB;
			if (m > 64'd4294967296) m = 64'd4294967296;
			return neg ? -longint'(m) : longint'(m);
		endfunction

		function bit near(longint p, longint c);
			longint diff;
			diff = p - c;
			if (diff < 0) diff = -diff;
			return diff < tol;
		endfunction

		function void note_ray(coord_t o[3], coord_t d[3]);
			longint tmin, tmax, ta, tb, sw;
			longint p[3];
			bit miss;
			ray_result_t r;
			tmin = SMIN;
			tmax = SMAX;
			miss = 0;
			for (int i = 0; i < 3; i++) begin
				if (miss) break;
				if (d[i] == 0) begin
					if (o[i] < bmin[i] || o[i] > bmax[i]) miss = 1;
				end else begin
					ta = slab_dist(bmin[i] - o[i], d[i]);
					tb = slab_dist(bmax[i] - o[i], d[i]);
					if (ta > tb) begin
						sw = ta; ta = tb; tb = sw;
					end
					if (ta > tmin) tmin = ta;
					if (tb < tmax) tmax = tb;
					if (tmin > tmax) miss = 1;
				end
			end
			if (tmax < 0) miss = 1;
			r = '{hit: 1'b0, hit_dist: '0, px: '0, py: '0, pz: '0, face: '0};
			rays++;
			if (!miss) begin
				for (int i = 0; i < 3; i++) p[i] = clamp_coord(o[i] + scaled_mul(tmin, d[i]));
				r.hit = 1'b1;
				r.hit_dist = coord_t'(tmin);
				r.px = coord_t'(p[0]);
				r.py = coord_t'(p[1]);
				r.pz = coord_t'(p[2]);
				if (near(p[0], bmin[0])) r.face = rbsi_pkg::FACE_NEG_X;
				else if (near(p[0], bmax[0])) r.face = rbsi_pkg::FACE_POS_X;
				else if (near(p[1], bmin[1])) r.face = rbsi_pkg::FACE_NEG_Y;
				else if (near(p[1], bmax[1])) r.face = rbsi_pkg::FACE_POS_Y;
				else if (near(p[2], bmin[2])) r.face = rbsi_pkg::FACE_NEG_Z;
				else r.face = rbsi_pkg::FACE_POS_Z;
				hits++;
			end else begin
				misses++;
			end
			pending_hits.push_back(r);
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
			errors++;
		endtask

		task check_result(ray_result_t got);
			ray_result_t want;
			if (pending_hits.size() == 0) begin
				report("unexpected result, hit", got.hit, 0);
				return;
			end
			want = pending_hits.pop_front();
			if (got.hit !== want.hit) report("hit", got.hit, want.hit);
			if (got.hit_dist !== want.hit_dist)
				report("hit_distance", got.hit_dist, want.hit_dist);
			if (got.px !== want.px) report("hit_x", got.px, want.px);
			if (got.py !== want.py) report("hit_y", got.py, want.py);
			if (got.pz !== want.pz) report("hit_z", got.pz, want.pz);
			if (got.face !== want.face) report("face", got.face, want.face);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	coord_t origin_x, origin_y, origin_z;
	coord_t direction_x, direction_y, direction_z;
	logic out_valid;
	logic out_ready;
	logic hit;
	coord_t hit_distance, hit_x, hit_y, hit_z;
	logic [rbsi_pkg::FACE_WIDTH-1:0] face;
	logic cfg_valid;
	logic cfg_ready;
	logic [rbsi_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [CW-1:0] cfg_data;

	box_scoreboard sb;
	int idle_cycles;
	int accepted_rays;
	bit timed_out;

	ray_box_slab_intersect #(.COORD_WIDTH(CW), .FRACTION_BITS(FB)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
		.direction_x(direction_x), .direction_y(direction_y), .direction_z(direction_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .hit_distance(hit_distance),
		.hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z), .face(face),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		{origin_x, origin_y, origin_z} = '0;
		{direction_x, direction_y, direction_z} = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{hit: hit, hit_dist: hit_distance, px: hit_x, py: hit_y,
				pz: hit_z, face: face});
	end

	// progress watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("watchdog expired with %0d results outstanding", sb.pending_hits.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: changing stall patterns plus one long hold-off to fill the pipeline
	initial begin
		int cyc;
		int mode;
		bit held;
		cyc = 0;
		held = 0;
		mode = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 400 == 0) mode = $urandom_range(0, 3);
			if (!held && accepted_rays >= 300) begin
				held = 1;
				out_ready = 1'b0;
				repeat (400) @(negedge clk);
			end
			case (mode)
				0: out_ready = 1'b1;
				1: out_ready = ($urandom_range(0, 99) < 70);
				2: out_ready = (cyc % 7) < 3;
				default: out_ready = ($urandom_range(0, 99) < 20);
			endcase
		end
	end

	task automatic write_reg(logic [rbsi_pkg::CFG_INDEX_WIDTH-1:0] idx, logic [CW-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_box(longint lo[3], longint hi[3], int tol);
		write_reg(rbsi_pkg::REG_BOX_MIN_X, CW'(lo[0]));
		write_reg(rbsi_pkg::REG_BOX_MIN_Y, CW'(lo[1]));
		write_reg(rbsi_pkg::REG_BOX_MIN_Z, CW'(lo[2]));
		write_reg(rbsi_pkg::REG_BOX_MAX_X, CW'(hi[0]));
		write_reg(rbsi_pkg::REG_BOX_MAX_Y, CW'(hi[1]));
		write_reg(rbsi_pkg::REG_BOX_MAX_Z, CW'(hi[2]));
		write_reg(rbsi_pkg::REG_FACE_TOL, tol);
	endtask

	// called at a falling edge; leaves valid high, returns after acceptance
	task automatic send_ray(coord_t o[3], coord_t d[3]);
		in_valid = 1'b1;
		{origin_x, origin_y, origin_z} = {o[0], o[1], o[2]};
		{direction_x, direction_y, direction_z} = {d[0], d[1], d[2]};
		do @(posedge clk); while (!in_ready);
		sb.note_ray(o, d);
		accepted_rays++;
		@(negedge clk);
	endtask

	task automatic drain();
		while (sb.pending_hits.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic longint rand_between(longint lo, longint hi);
		longint unsigned span;
		if (hi <= lo) return lo;
		span = hi - lo + 1;
		return lo + longint'({$urandom, $urandom} % span);
	endfunction

	task automatic make_ray(output coord_t o[3], output coord_t d[3]);
		int kind;
		longint k;
		kind = $urandom_range(0, 99);
		for (int i = 0; i < 3; i++) begin
			if (kind < 55) begin
				// aimed through a point of the box
				d[i] = coord_t'(longint'($urandom_range(0, 1 << 18)) - (1 << 17));
				k = $urandom_range(0, 12);
				o[i] = coord_t'(clamp_coord(rand_between(sb.bmin[i], sb.bmax[i])
					- (k * longint'(d[i]) >>> 1)));
				if (kind < 15 && i == kind % 3) d[i] = '0;
			end else if (kind < 90) begin
				o[i] = $urandom;
				d[i] = $urandom;
			end else begin
				o[i] = ($urandom_range(0, 1)) ? coord_t'(SMAX) : coord_t'(SMIN);
				case ($urandom_range(0, 3))
					0: d[i] = '0;
					1: d[i] = coord_t'(SMAX);
					2: d[i] = coord_t'(SMIN);
					default: d[i] = coord_t'($urandom_range(1, 3));
				endcase
			end
		end
	endtask

	task automatic random_rays(int count);
		coord_t o[3], d[3];
		int burst;
		int sent;
		sent = 0;
		while (sent < count) begin
			burst = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
			for (int b = 0; b < burst && sent < count; b++) begin
				make_ray(o, d);
				send_ray(o, d);
				sent++;
			end
			in_valid = 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
		end
		in_valid = 1'b0;
	endtask

	task automatic directed_rays();
		coord_t o[3], d[3];
		longint dirs[12][6];
		longint h;
		longint z;
		h = ONE / 2;
		z = 64'sd0;
		dirs = '{
			'{-ONE, h, h, ONE, z, z},
			'{2*ONE, h, h, -ONE, z, z},
			'{h, -ONE, h, z, ONE, z},
			'{h, 2*ONE, h, z, -ONE, z},
			'{h, h, -ONE, z, z, ONE},
			'{h, h, 2*ONE, z, z, -ONE},
			'{h, h, h, ONE, ONE, ONE},
			'{h, h, h, z, z, z},
			'{2*ONE, h, h, z, z, z},
			'{2*ONE, h, h, ONE, z, z},
			'{-ONE, 2*ONE, h, ONE, ONE/10, z},
			'{-ONE, -ONE, -ONE, 64'sd1, 64'sd1, 64'sd1}
		};
		for (int n = 0; n < 12; n++) begin
			for (int i = 0; i < 3; i++) begin
				o[i] = coord_t'(dirs[n][i]);
				d[i] = coord_t'(dirs[n][3+i]);
			end
			send_ray(o, d);
		end
		// extremes of every field
		for (int n = 0; n < 4; n++) begin
			for (int i = 0; i < 3; i++) begin
				o[i] = n[0] ? coord_t'(SMAX) : coord_t'(SMIN);
				d[i] = n[1] ? coord_t'(SMAX) : coord_t'(SMIN);
			end
			send_ray(o, d);
		end
		for (int i = 0; i < 3; i++) begin
			o[i] = coord_t'(SMIN);
			d[i] = 1;
		end
		send_ray(o, d);
		in_valid = 1'b0;
	endtask

	initial begin
		longint lo[3], hi[3];
		longint c;
		int phases;
		phases = 1;
		@(posedge arst_n);
		@(negedge clk);
		// reset box first, then rewritten settings
		directed_rays();
		random_rays(140);
		drain();
		for (int ph = 0; ph < 8; ph++) begin
			for (int i = 0; i < 3; i++) begin
				case (ph)
					0: begin lo[i] = 0; hi[i] = ONE; end
					1: begin lo[i] = SMIN; hi[i] = SMAX; end
					2: begin lo[i] = (i == 0) ? ONE : -ONE; hi[i] = (i == 0) ? -ONE : ONE; end
					3: begin lo[i] = SMAX; hi[i] = SMAX; end
					default: begin
						c = rand_between(-(1 << 22), 1 << 22);
						lo[i] = c;
						hi[i] = c + rand_between(0, 1 << 19);
					end
				endcase
			end
			case (ph)
				0: set_box(lo, hi, 0);
				1: set_box(lo, hi, 65535);
				default: set_box(lo, hi, $urandom_range(0, 65535));
			endcase
			phases++;
			random_rays(125);
			drain();
		end
		if (sb.pending_hits.size() != 0) begin
			sb.report("results never delivered", sb.pending_hits.size(), 0);
		end
		$display("%0d rays over %0d box settings: %0d hits, %0d misses",
			sb.rays, phases, sb.hits, sb.misses);
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
